FILE: hdl/vsplat_pkg.sv
// ----------------------------------------------------------------------------
// vsplat_pkg: shared types and constants for the voxel splat unit
// Commands, register indexes and the axis-index request word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vsplat_pkg;

	localparam logic [1:0] CMD_SPLAT      = 2'd0;
	localparam logic [1:0] CMD_CLEAR_MARK = 2'd1;
	localparam logic [1:0] CMD_READ       = 2'd2;
	localparam logic [1:0] CMD_CLEAR_ALL  = 2'd3;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] REG_INV_RES  = 3'd3;
	localparam logic [2:0] REG_REACH    = 3'd4;
	localparam logic [2:0] REG_WEIGHTED = 3'd5;

	localparam int FRAC_BITS = 20;
	localparam int POS_W     = 24;
	localparam int DIFF_W    = 27;
	localparam int PROD_W    = 44;
	localparam int IDX_W     = 24;

	// index request to the shared axis unit
	typedef struct packed {
		logic signed [POS_W-1:0] pos;
		logic signed [POS_W-1:0] org;
		logic signed [4:0]       off;
	} axis_req_t;

endpackage

FILE: hdl/voxel_splat_once_per_frame_unit.sv
// ----------------------------------------------------------------------------
// voxel_splat_once_per_frame_unit: density grid splatting
// Sequencer, grid memories and configuration over a shared index unit.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake            | Payload
// command  | in        | start, busy          | cmd pos_x/y/z weight cell_x/y/z
// result   | out       | done (one cycle)     | cell_value cells_added centre_outside
// config   | in        | cfg_we, cfg_idx      | cfg_data
//
// Splat: index work for each offset of each axis, one centre check, then the
// address, read and write states per offset triple (no read where it leaves the
// grid), (2*min(reach,MAX_REACH)+1)^3 triples, and the done state to post the word.
// Read: ST_READ, ST_READ2, done; only done off the grid. Clear marks / all: one cell per cycle.
// After reset a clearing pass over all GRID_X*GRID_Y*GRID_Z cells holds busy high.
// The result receiver cannot stall.
`timescale 1ns / 1ps

module voxel_splat_once_per_frame_unit #(
	parameter int GRID_X    = 32,
	parameter int GRID_Y    = 32,
	parameter int GRID_Z    = 32,
	parameter int MAX_REACH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	input  logic [15:0]        weight,
	input  logic [4:0]         cell_x,
	input  logic [4:0]         cell_y,
	input  logic [4:0]         cell_z,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [23:0]        cfg_data,
	output logic               done,
	output logic [31:0]        cell_value,
	output logic [9:0]         cells_added,
	output logic               centre_outside
);
	localparam int NCELLS = GRID_X * GRID_Y * GRID_Z;
	localparam int AW     = $clog2(NCELLS);
	localparam int XW     = $clog2(GRID_X);
	localparam int YW     = $clog2(GRID_Y);
	localparam int ZW     = $clog2(GRID_Z);
	localparam int NOFF   = 2 * MAX_REACH + 1;
	localparam int IDX_W  = vsplat_pkg::IDX_W;

	localparam logic [3:0] ST_WIPE  = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_AXIS  = 4'd2;
	localparam logic [3:0] ST_CELL  = 4'd3;
	localparam logic [3:0] ST_RD    = 4'd4;
	localparam logic [3:0] ST_WR    = 4'd5;
	localparam logic [3:0] ST_READ  = 4'd6;
	localparam logic [3:0] ST_READ2 = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;
	localparam logic [3:0] ST_ADDR  = 4'd9;

	logic [3:0] state_q;

	logic signed [23:0] org_x_q, org_y_q, org_z_q;
	logic [15:0] inv_res_q;
	logic [2:0]  reach_q;
	logic        weighted_q;

	logic [1:0]  cmd_q;
	logic signed [23:0] px_q, py_q, pz_q;
	logic [31:0] incr_q;

	// per-axis index tables, one entry per offset step
	logic signed [IDX_W-1:0] tx_q [NOFF];
	logic signed [IDX_W-1:0] ty_q [NOFF];
	logic signed [IDX_W-1:0] tz_q [NOFF];

	logic [1:0]  ax_axis_q;
	logic [4:0]  ax_off_q;
	logic [1:0]  wb_axis_q;
	logic [4:0]  wb_off_q;
	logic        wb_vld_q;

	logic [4:0]  i_q, j_q, k_q;
	logic [4:0]  rmax;
	logic [AW-1:0] addr_q;
	logic [AW:0]   wipe_q;
	logic          wipe_den_q;
	logic [9:0]    added_q;
	logic          outside_q;
	logic [31:0]   value_q;

	logic [31:0] den_mem [NCELLS];
	logic        mark_mem[NCELLS];
	logic [31:0] den_rd_q;
	logic        mark_rd_q;

	vsplat_pkg::axis_req_t req;
	logic signed [IDX_W-1:0] ax_idx;
	logic signed [4:0] off_s;

	assign rmax = ({2'd0, reach_q} > 5'(MAX_REACH)) ? 5'(MAX_REACH) : {2'd0, reach_q};
	assign off_s = $signed(ax_off_q) - $signed(rmax);

	always_comb begin
		req.off = off_s;
		unique case (ax_axis_q)
			2'd0:    begin req.pos = px_q; req.org = org_x_q; end
			2'd1:    begin req.pos = py_q; req.org = org_y_q; end
			default: begin req.pos = pz_q; req.org = org_z_q; end
		endcase
	end

	vsplat_axis u_axis (
		.clk     (clk),
		.req     (req),
		.inv_res (inv_res_q),
		.idx     (ax_idx)
	);

	// current triple indexes
	logic signed [IDX_W-1:0] sx, sy, sz;
	logic in_grid;
	assign sx = tx_q[i_q[$clog2(NOFF)-1:0]];
	assign sy = ty_q[j_q[$clog2(NOFF)-1:0]];
	assign sz = tz_q[k_q[$clog2(NOFF)-1:0]];
	assign in_grid = (sx >= 0) && (sx < IDX_W'(GRID_X)) && (sy >= 0)
		&& (sy < IDX_W'(GRID_Y)) && (sz >= 0) && (sz < IDX_W'(GRID_Z));

	logic signed [IDX_W-1:0] c_x, c_y, c_z;
	assign c_x = tx_q[rmax[$clog2(NOFF)-1:0]];
	assign c_y = ty_q[rmax[$clog2(NOFF)-1:0]];
	assign c_z = tz_q[rmax[$clog2(NOFF)-1:0]];

	logic [32:0] sum;
	assign sum = {1'b0, den_rd_q} + {1'b0, incr_q};

	logic mem_we, mark_we, mark_wd;
	logic [31:0] den_wd;
	logic [AW-1:0] mem_wa;
	always_comb begin
		mem_we  = 1'b0;
		mark_we = 1'b0;
		mark_wd = 1'b0;
		den_wd  = '0;
		mem_wa  = addr_q;
		if (state_q == ST_WIPE) begin
			mem_wa  = wipe_q[AW-1:0];
			mark_we = 1'b1;
			mem_we  = wipe_den_q;
		end else if (state_q == ST_WR && in_grid && !mark_rd_q) begin
			mem_we  = 1'b1;
			mark_we = 1'b1;
			mark_wd = 1'b1;
			den_wd  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			den_mem[mem_wa] <= den_wd;
		if (mark_we)
			mark_mem[mem_wa] <= mark_wd;
		den_rd_q  <= den_mem[addr_q];
		mark_rd_q <= mark_mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q    <= '0;
			org_y_q    <= '0;
			org_z_q    <= '0;
			inv_res_q  <= 16'd4096;
			reach_q    <= 3'd2;
			weighted_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				vsplat_pkg::REG_ORIGIN_X: org_x_q    <= cfg_data;
				vsplat_pkg::REG_ORIGIN_Y: org_y_q    <= cfg_data;
				vsplat_pkg::REG_ORIGIN_Z: org_z_q    <= cfg_data;
				vsplat_pkg::REG_INV_RES:  inv_res_q  <= cfg_data[15:0];
				vsplat_pkg::REG_REACH:    reach_q    <= cfg_data[2:0];
				vsplat_pkg::REG_WEIGHTED: weighted_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wb_vld_q) begin
			unique case (wb_axis_q)
				2'd0:    tx_q[wb_off_q[$clog2(NOFF)-1:0]] <= ax_idx;
				2'd1:    ty_q[wb_off_q[$clog2(NOFF)-1:0]] <= ax_idx;
				default: tz_q[wb_off_q[$clog2(NOFF)-1:0]] <= ax_idx;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_WIPE;
			wipe_q         <= '0;
			wipe_den_q     <= 1'b1;
			done           <= 1'b0;
			cell_value     <= '0;
			cells_added    <= '0;
			centre_outside <= 1'b0;
			ax_axis_q      <= '0;
			ax_off_q       <= '0;
			wb_vld_q       <= 1'b0;
			wb_axis_q      <= '0;
			wb_off_q       <= '0;
			i_q            <= '0;
			j_q            <= '0;
			k_q            <= '0;
			added_q        <= '0;
			outside_q      <= 1'b0;
			value_q        <= '0;
			addr_q         <= '0;
			cmd_q          <= '0;
		end else begin
			done     <= 1'b0;
			wb_vld_q <= 1'b0;
			unique case (state_q)
				ST_WIPE: begin
					wipe_q <= wipe_q + 1'b1;
					if (wipe_q == (AW+1)'(NCELLS - 1))
						state_q <= (cmd_q == vsplat_pkg::CMD_SPLAT) ? ST_IDLE : ST_DONE;
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q     <= cmd;
						added_q   <= '0;
						outside_q <= 1'b0;
						value_q   <= '0;
						unique case (cmd)
							vsplat_pkg::CMD_SPLAT: begin
								ax_axis_q <= '0;
								ax_off_q  <= '0;
								state_q   <= ST_AXIS;
							end
							vsplat_pkg::CMD_READ: begin
								if ({27'd0, cell_x} < GRID_X && {27'd0, cell_y} < GRID_Y
									&& {27'd0, cell_z} < GRID_Z) begin
									addr_q  <= AW'((cell_x * GRID_Y + cell_y) * GRID_Z
										+ cell_z);
									state_q <= ST_READ;
								end else begin
									state_q <= ST_DONE;
								end
							end
							default: begin
								wipe_q     <= '0;
								wipe_den_q <= (cmd == vsplat_pkg::CMD_CLEAR_ALL);
								state_q    <= ST_WIPE;
							end
						endcase
					end
				end
				ST_AXIS: begin
					// issue every offset of every axis; write back in the next cycle
					wb_vld_q  <= (ax_axis_q != 2'd3);
					wb_axis_q <= ax_axis_q;
					wb_off_q  <= ax_off_q;
					if (ax_axis_q == 2'd3) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_ADDR;
					end else if (ax_off_q == {rmax[3:0], 1'b0}) begin
						ax_off_q  <= '0;
						ax_axis_q <= ax_axis_q + 1'b1;
					end else begin
						ax_off_q <= ax_off_q + 1'b1;
					end
				end
				ST_ADDR: begin
					if (c_x < 0 || c_x >= IDX_W'(GRID_X) || c_y < 0 || c_y >= IDX_W'(GRID_Y)
						|| c_z < 0 || c_z >= IDX_W'(GRID_Z))
						outside_q <= 1'b1;
					state_q <= ST_CELL;
				end
				ST_CELL: begin
					addr_q <= AW'((sx[XW:0] * GRID_Y + sy[YW:0]) * GRID_Z + sz[ZW:0]);
					if (in_grid)
						state_q <= ST_RD;
					else
						state_q <= ST_WR;
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					if (in_grid && !mark_rd_q && added_q != 10'd1023)
						added_q <= added_q + 1'b1;
					if (k_q != {rmax[3:0], 1'b0}) begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_CELL;
					end else if (j_q != {rmax[3:0], 1'b0}) begin
						k_q     <= '0;
						j_q     <= j_q + 1'b1;
						state_q <= ST_CELL;
					end else if (i_q != {rmax[3:0], 1'b0}) begin
						k_q     <= '0;
						j_q     <= '0;
						i_q     <= i_q + 1'b1;
						state_q <= ST_CELL;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_READ:  state_q <= ST_READ2;
				ST_READ2: begin
					value_q <= den_rd_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					done           <= 1'b1;
					cell_value     <= value_q;
					cells_added    <= added_q;
					centre_outside <= outside_q;
					cmd_q          <= vsplat_pkg::CMD_SPLAT;
					state_q        <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			px_q   <= pos_x;
			py_q   <= pos_y;
			pz_q   <= pos_z;
			incr_q <= weighted_q ? {16'd0, weight} : 32'd256;
		end
	end
endmodule

FILE: hdl/vsplat_axis.sv
// ----------------------------------------------------------------------------
// vsplat_axis: shared index unit
// Registered multiply, then floor/ceil/round of one axis coordinate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vsplat_axis (
	input  logic                                     clk,
	input  vsplat_pkg::axis_req_t                    req,
	input  logic [15:0]                              inv_res,
	output logic signed [vsplat_pkg::IDX_W-1:0]      idx
);
	logic signed [vsplat_pkg::DIFF_W-1:0] diff;
	logic signed [vsplat_pkg::PROD_W-1:0] prod_s1;
	logic signed [4:0]                    off_s1;
	logic signed [vsplat_pkg::PROD_W-1:0] adj;

	assign diff = vsplat_pkg::DIFF_W'(req.pos) - vsplat_pkg::DIFF_W'(req.org)
		+ vsplat_pkg::DIFF_W'($signed({req.off, 8'd0}));

	always_ff @(posedge clk) begin
		prod_s1 <= vsplat_pkg::PROD_W'(diff) * $signed({1'b0, inv_res});
		off_s1  <= req.off;
	end

	always_comb begin
		if (off_s1 == 5'sd0) begin
			// half away from zero
			if (prod_s1 < 0)
				adj = prod_s1 + vsplat_pkg::PROD_W'((1 << (vsplat_pkg::FRAC_BITS-1)) - 1);
			else
				adj = prod_s1 + vsplat_pkg::PROD_W'(1 << (vsplat_pkg::FRAC_BITS-1));
		end else if (off_s1 < 0) begin
			adj = prod_s1 + vsplat_pkg::PROD_W'((1 << vsplat_pkg::FRAC_BITS) - 1);
		end else begin
			adj = prod_s1;
		end
	end

	assign idx = adj[vsplat_pkg::FRAC_BITS +: vsplat_pkg::IDX_W];
endmodule
